// ===== rtl/hsvb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB conversion package
// Shared widths, constants, codes and control types for the color pipeline.
// ----------------------------------------------------------------------------
package hsvb_pkg;

   localparam int HueWidth    = 9;
   localparam int SatInWidth  = 8;
   localparam int CsrWidth    = 8;
   localparam int WordWidth   = 32;
   localparam int LevelWidth  = 7;   // percent 0..100
   localparam int FracWidth   = 6;   // 0..59
   localparam int TermWidth   = 13;  // 0..6000
   localparam int ProdWidth   = 20;  // V * term, up to 600000
   localparam int NumerWidth  = 24;  // 17 * V * term
   localparam int RecipWidth  = 25;
   localparam int RecipShift  = 40;
   localparam int ChanWidth   = 8;
   localparam int NumLanes    = 4;

   localparam logic [HueWidth-1:0]   HueWrap    = 9'd360;
   localparam logic [LevelWidth-1:0] FullPct    = 7'd100;
   localparam logic [TermWidth-1:0]  FullTerm   = 13'd6000;
   localparam logic [FracWidth-1:0]  SectorDeg  = 6'd60;
   // ceil(2^40 / 40000): floor(255*P/600000) equals floor(17*P/40000).
   localparam logic [RecipWidth-1:0] Recip      = 25'd27487791;
   localparam logic [7:0]            TopByte    = 8'hFF;
   localparam logic [CsrWidth-1:0]   CsrReset   = 8'd5;

   typedef enum logic [0:0] {
      CsrBrightSetting = 1'b0,
      CsrBrightLimit   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      SectorRedYellow   = 3'd0,
      SectorYellowGreen = 3'd1,
      SectorGreenCyan   = 3'd2,
      SectorCyanBlue    = 3'd3,
      SectorBlueMagenta = 3'd4,
      SectorMagentaRed  = 3'd5
   } sector_type;

   // Lane roles: full, rising, falling and floor.
   localparam int LaneFull = 0;
   localparam int LaneUp   = 1;
   localparam int LaneDown = 2;
   localparam int LaneLow  = 3;

   typedef logic [TermWidth-1:0] term_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_load_type;

endpackage

// ===== rtl/hsvb_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one hue and saturation beat.
// ----------------------------------------------------------------------------
interface hsvb_req_if;
   import hsvb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [HueWidth-1:0]   hue;
   logic [SatInWidth-1:0] saturation;

   modport source (output valid, output hue, output saturation, input ready);
   modport sink   (input valid, input hue, input saturation, output ready);

endinterface

// ===== rtl/hsvb_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one packed color word beat.
// ----------------------------------------------------------------------------
interface hsvb_rsp_if;
   import hsvb_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] color_word;

   modport source (output valid, output color_word, input ready);
   modport sink   (input valid, input color_word, output ready);

endinterface

// ===== rtl/hsvb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV front end
// Stage 1 clamps the inputs and splits the hue into sector and fraction.
// Stage 2 forms the four saturation terms 6000 - S*G.
// ----------------------------------------------------------------------------
module hsvb_front import hsvb_pkg::*; (
   input  logic                  clock,
   input  stage_load_type        load,
   input  logic [HueWidth-1:0]   hue,
   input  logic [SatInWidth-1:0] saturation,
   input  logic [CsrWidth-1:0]   bright_setting,
   input  logic [CsrWidth-1:0]   bright_limit,
   output logic [LevelWidth-1:0] level,
   output sector_type            sector,
   output term_type              terms [NumLanes]
);

   logic [HueWidth-1:0]   hue_wrap;
   logic [HueWidth-1:0]   sector_base;
   logic [HueWidth-1:0]   frac_wide;
   sector_type            sector_in;
   logic [CsrWidth-1:0]   capped;
   logic [LevelWidth-1:0] level_in;
   logic [LevelWidth-1:0] sat_in;

   logic [LevelWidth-1:0] level_s1_ff;
   logic [LevelWidth-1:0] sat_s1_ff;
   logic [FracWidth-1:0]  frac_s1_ff;
   sector_type            sector_s1_ff;

   logic [TermWidth-1:0]  prod_up;
   logic [TermWidth-1:0]  prod_down;
   logic [TermWidth-1:0]  prod_low;
   logic [FracWidth-1:0]  frac_rev;

   logic [LevelWidth-1:0] level_s2_ff;
   sector_type            sector_s2_ff;
   term_type              terms_s2_ff [NumLanes];

   // Stage 1: clamps and sector search.
   always_comb begin
      hue_wrap = (hue >= HueWrap) ? '0 : hue;
      priority if (hue_wrap >= 9'd300) begin
         sector_in   = SectorMagentaRed;
         sector_base = 9'd300;
      end else if (hue_wrap >= 9'd240) begin
         sector_in   = SectorBlueMagenta;
         sector_base = 9'd240;
      end else if (hue_wrap >= 9'd180) begin
         sector_in   = SectorCyanBlue;
         sector_base = 9'd180;
      end else if (hue_wrap >= 9'd120) begin
         sector_in   = SectorGreenCyan;
         sector_base = 9'd120;
      end else if (hue_wrap >= 9'd60) begin
         sector_in   = SectorYellowGreen;
         sector_base = 9'd60;
      end else begin
         sector_in   = SectorRedYellow;
         sector_base = 9'd0;
      end
      frac_wide = hue_wrap - sector_base;

      // The auto flag in bit 7 of the setting plays no part here.
      capped = ({1'b0, bright_setting[LevelWidth-1:0]} > bright_limit) ?
               bright_limit : {1'b0, bright_setting[LevelWidth-1:0]};
      level_in = (capped > {1'b0, FullPct}) ? FullPct : capped[LevelWidth-1:0];
      sat_in   = (saturation > {1'b0, FullPct}) ? FullPct : saturation[LevelWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (load.s1) begin
         level_s1_ff  <= level_in;
         sat_s1_ff    <= sat_in;
         frac_s1_ff   <= frac_wide[FracWidth-1:0];
         sector_s1_ff <= sector_in;
      end
   end

   // Stage 2: saturation weights.
   always_comb begin
      frac_rev  = SectorDeg - frac_s1_ff;
      prod_up   = TermWidth'(sat_s1_ff) * TermWidth'(frac_rev);
      prod_down = TermWidth'(sat_s1_ff) * TermWidth'(frac_s1_ff);
      prod_low  = TermWidth'(sat_s1_ff) * TermWidth'(SectorDeg);
   end

   always_ff @(posedge clock) begin
      if (load.s2) begin
         level_s2_ff            <= level_s1_ff;
         sector_s2_ff           <= sector_s1_ff;
         terms_s2_ff[LaneFull]  <= FullTerm;
         terms_s2_ff[LaneUp]    <= FullTerm - prod_up;
         terms_s2_ff[LaneDown]  <= FullTerm - prod_down;
         terms_s2_ff[LaneLow]   <= FullTerm - prod_low;
      end
   end

   assign level  = level_s2_ff;
   assign sector = sector_s2_ff;
   assign terms  = terms_s2_ff;

endmodule

// ===== rtl/hsvb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel scaling lane
// Stage 3 forms V * term; stage 4 divides 255 * V * term by 600000 through
// an exact reciprocal multiply.
// ----------------------------------------------------------------------------
module hsvb_lane import hsvb_pkg::*; (
   input  logic                  clock,
   input  stage_load_type        load,
   input  logic [LevelWidth-1:0] level,
   input  term_type              term,
   output logic [ChanWidth-1:0]  chan
);

   localparam int QuotWidth = NumerWidth + RecipWidth;

   logic [ProdWidth-1:0]  prod_s3_ff;
   logic [NumerWidth-1:0] numer;
   logic [QuotWidth-1:0]  quot_full;
   logic [ChanWidth-1:0]  chan_s4_ff;

   always_ff @(posedge clock) begin
      if (load.s3) begin
         prod_s3_ff <= ProdWidth'(level) * ProdWidth'(term);
      end
   end

   // 17 * P, then the reciprocal multiply; the quotient never exceeds 255.
   always_comb begin
      numer     = (NumerWidth'(prod_s3_ff) << 4) + NumerWidth'(prod_s3_ff);
      quot_full = QuotWidth'(numer) * QuotWidth'(Recip);
   end

   always_ff @(posedge clock) begin
      if (load.s4) begin
         chan_s4_ff <= quot_full[RecipShift +: ChanWidth];
      end
   end

   assign chan = chan_s4_ff;

endmodule

// ===== rtl/hsv_to_rgb_with_brightness_cap_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB with brightness cap
// Each accepted request beat passes through stages 1 to 4 to its response beat.
// Throughput: one beat per cycle unless rsp ready stalls; the four stages
// each hold a beat and move it on once the next has room; bubbles close up.
// Reset clears all stage valid bits and sets both brightness registers to 5.
// ----------------------------------------------------------------------------
module hsv_to_rgb_with_brightness_cap_unit import hsvb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   hsvb_req_if.sink            req_chan,
   hsvb_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  csr_index_type       csr_index,
   input  logic [CsrWidth-1:0] csr_write_data
);

   logic [CsrWidth-1:0]   bright_setting_ff;
   logic [CsrWidth-1:0]   bright_limit_ff;
   logic [3:0]            valid_ff;
   logic [3:0]            valid_in;
   stage_load_type        load;
   logic [LevelWidth-1:0] level_s2;
   sector_type            sector_s2;
   sector_type            sector_s3_ff;
   sector_type            sector_s4_ff;
   term_type              terms_s2 [NumLanes];
   logic [ChanWidth-1:0]  chans [NumLanes];
   logic [ChanWidth-1:0]  red;
   logic [ChanWidth-1:0]  green;
   logic [ChanWidth-1:0]  blue;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_setting_ff <= CsrReset;
         bright_limit_ff   <= CsrReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrBrightSetting: bright_setting_ff <= csr_write_data;
            CsrBrightLimit:   bright_limit_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A stage loads when it is empty or its contents move on this cycle.
   always_comb begin
      load.s4  = !valid_ff[3] || rsp_chan.ready;
      load.s3  = !valid_ff[2] || load.s4;
      load.s2  = !valid_ff[1] || load.s3;
      load.s1  = !valid_ff[0] || load.s2;
      valid_in[0] = load.s1 ? req_chan.valid : valid_ff[0];
      valid_in[1] = load.s2 ? valid_ff[0]    : valid_ff[1];
      valid_in[2] = load.s3 ? valid_ff[1]    : valid_ff[2];
      valid_in[3] = load.s4 ? valid_ff[2]    : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = load.s1;
   assign rsp_chan.valid = valid_ff[3];

   hsvb_front u_front (
      .clock          (clock),
      .load           (load),
      .hue            (req_chan.hue),
      .saturation     (req_chan.saturation),
      .bright_setting (bright_setting_ff),
      .bright_limit   (bright_limit_ff),
      .level          (level_s2),
      .sector         (sector_s2),
      .terms          (terms_s2)
   );

   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      hsvb_lane u_lane (
         .clock (clock),
         .load  (load),
         .level (level_s2),
         .term  (terms_s2[i]),
         .chan  (chans[i])
      );
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         sector_s3_ff <= sector_s2;
      end
      if (load.s4) begin
         sector_s4_ff <= sector_s3_ff;
      end
   end

   always_comb begin
      unique case (sector_s4_ff)
         SectorRedYellow: begin
            red = chans[LaneFull]; green = chans[LaneUp];   blue = chans[LaneLow];
         end
         SectorYellowGreen: begin
            red = chans[LaneDown]; green = chans[LaneFull]; blue = chans[LaneLow];
         end
         SectorGreenCyan: begin
            red = chans[LaneLow];  green = chans[LaneFull]; blue = chans[LaneUp];
         end
         SectorCyanBlue: begin
            red = chans[LaneLow];  green = chans[LaneDown]; blue = chans[LaneFull];
         end
         SectorBlueMagenta: begin
            red = chans[LaneUp];   green = chans[LaneLow];  blue = chans[LaneFull];
         end
         default: begin
            red = chans[LaneFull]; green = chans[LaneLow];  blue = chans[LaneDown];
         end
      endcase
   end

   assign rsp_chan.color_word = {TopByte, blue, green, red};

endmodule
